FILE: rtl/core/dcc_pkg.sv
// Shared types and constants for the track waveform sender.
// Holds the item structs, the configuration struct and register indexes.
// No dependencies.
package dcc_pkg;

    // Input item: a time tick or a message table write.
    typedef struct packed {
        logic        kind;
        logic [2:0]  entry_index;
        logic [63:0] entry_word;
    } t_in_item;

    // Result item: line state after the item.
    typedef struct packed {
        logic       line_level;
        logic       frame_active;
        logic [2:0] frame_index;
    } t_out_item;

    // Configuration register set.
    typedef struct packed {
        logic [3:0]  message_count;
        logic [6:0]  bit_length;
        logic [15:0] one_half_ticks;
        logic [15:0] zero_half_ticks;
        logic [19:0] start_gap_ticks;
        logic [23:0] frame_period_ticks;
    } t_cfg;

    // Item kinds.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Register indexes on the configuration port.
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_MESSAGE_COUNT = 3'd0;
    localparam logic [2:0] REG_BIT_LENGTH    = 3'd1;
    localparam logic [2:0] REG_ONE_HALF      = 3'd2;
    localparam logic [2:0] REG_ZERO_HALF     = 3'd3;
    localparam logic [2:0] REG_START_GAP     = 3'd4;
    localparam logic [2:0] REG_FRAME_PERIOD  = 3'd5;

    // Register reset values.
    localparam logic [3:0]  RST_MESSAGE_COUNT = 4'd0;
    localparam logic [6:0]  RST_BIT_LENGTH    = 7'd42;
    localparam logic [15:0] RST_ONE_HALF      = 16'd58;
    localparam logic [15:0] RST_ZERO_HALF     = 16'd100;
    localparam logic [19:0] RST_START_GAP     = 20'd500;
    localparam logic [23:0] RST_FRAME_PERIOD  = 24'd20000;

    // Longest message in bits.
    localparam logic [6:0] MAX_BITS = 7'd64;

endpackage

FILE: rtl/core/dcc_cfg_regs.sv
// APB-style configuration register file for the track waveform sender.
// Depends on dcc_pkg for the register indexes, reset values and t_cfg.
module dcc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dcc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output dcc_pkg::t_cfg              o_cfg
);
    import dcc_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_reg_idx;
    logic       w_wr;

    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_wr      = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.message_count      <= RST_MESSAGE_COUNT;
            r_cfg.bit_length         <= RST_BIT_LENGTH;
            r_cfg.one_half_ticks     <= RST_ONE_HALF;
            r_cfg.zero_half_ticks    <= RST_ZERO_HALF;
            r_cfg.start_gap_ticks    <= RST_START_GAP;
            r_cfg.frame_period_ticks <= RST_FRAME_PERIOD;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_MESSAGE_COUNT: r_cfg.message_count      <= pwdata[3:0];
                REG_BIT_LENGTH:    r_cfg.bit_length         <= pwdata[6:0];
                REG_ONE_HALF:      r_cfg.one_half_ticks     <= pwdata[15:0];
                REG_ZERO_HALF:     r_cfg.zero_half_ticks    <= pwdata[15:0];
                REG_START_GAP:     r_cfg.start_gap_ticks    <= pwdata[19:0];
                REG_FRAME_PERIOD:  r_cfg.frame_period_ticks <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            REG_MESSAGE_COUNT: prdata = {28'd0, r_cfg.message_count};
            REG_BIT_LENGTH:    prdata = {25'd0, r_cfg.bit_length};
            REG_ONE_HALF:      prdata = {16'd0, r_cfg.one_half_ticks};
            REG_ZERO_HALF:     prdata = {16'd0, r_cfg.zero_half_ticks};
            REG_START_GAP:     prdata = {12'd0, r_cfg.start_gap_ticks};
            REG_FRAME_PERIOD:  prdata = {8'd0, r_cfg.frame_period_ticks};
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/dcc_bit_waveform_sender.sv
// Track waveform sender: one tick or table-write item per cycle; uses dcc_pkg and dcc_cfg_regs.
// The result of an item is registered in the output register at its accept edge.
// Throughput: one item per cycle. The input stalls only while a result waits in the output
// register and the receiver holds it off; it accepts again in the cycle that result is taken.
// Reset (synchronous, active low): line idle high, timers and entry pointer cleared,
// registers at their defaults; the message table is not cleared and must be written first.
module dcc_bit_waveform_sender #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  dcc_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output dcc_pkg::t_out_item         o_out_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dcc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import dcc_pkg::*;

    // Only eight entries can be addressed by a write.
    localparam int TBL_DEPTH = (QUEUE_DEPTH < 8) ? QUEUE_DEPTH : 8;
    localparam int TBL_IDX_W = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    // Frame phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_GAP  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_LOW  = 2'd3;

    t_cfg        w_cfg;
    logic [63:0] r_tbl [TBL_DEPTH];

    logic [1:0]  r_phase,        n_phase;
    logic [19:0] r_half_timer,   n_half_timer;
    logic [23:0] r_period_timer, n_period_timer;
    logic [5:0]  r_bit_pos,      n_bit_pos;
    logic [3:0]  r_cur_entry,    n_cur_entry;
    logic        r_level,        n_level;
    logic        r_out_valid;
    t_out_item   r_out_item,     n_out_item;

    logic        w_accept;
    logic        w_tick;
    logic        w_wr;
    logic [3:0]  w_eff_count;
    logic [6:0]  w_eff_bits;
    logic        w_start;
    logic [3:0]  w_cur_sel;
    logic [4:0]  w_cur_plus;
    logic [3:0]  w_cur_next;
    logic [5:0]  w_bp_sel;
    logic [63:0] w_word;
    logic [63:0] w_shifted;
    logic [19:0] w_half0;
    logic [19:0] w_half1;
    logic        w_last_bit;

    // Half period of a bit, zero counted as one tick.
    function automatic logic [19:0] half_len(input logic b, input t_cfg c);
        logic [15:0] h;
        h = b ? c.one_half_ticks : c.zero_half_ticks;
        if (h == 16'd0) begin
            h = 16'd1;
        end
        return {4'd0, h};
    endfunction

    dcc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake: the output register frees as its item is taken.
    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_tick      = w_accept & (i_in_item.kind == KIND_TICK);
    assign w_wr        = w_accept & (i_in_item.kind == KIND_WRITE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Clamped settings.
    assign w_eff_count = ({3'd0, w_cfg.message_count} > 7'(QUEUE_DEPTH)) ?
                         4'(QUEUE_DEPTH) : w_cfg.message_count;
    assign w_eff_bits  = (w_cfg.bit_length > MAX_BITS) ? MAX_BITS : w_cfg.bit_length;

    // Frame start and the entry it sends.
    assign w_start    = (r_phase == PH_IDLE) && (w_eff_count != 4'd0) &&
                        (r_period_timer == 24'd0);
    assign w_cur_sel  = (w_start && (r_cur_entry >= w_eff_count)) ? 4'd0 : r_cur_entry;
    assign w_cur_plus = {1'b0, w_cur_sel} + 5'd1;
    assign w_cur_next = (w_cur_plus >= {1'b0, w_eff_count}) ? 4'd0 : w_cur_plus[3:0];

    // Bit selection: the current bit and the one after it.
    assign w_bp_sel   = (w_start || (r_phase == PH_GAP)) ? 6'd0 : r_bit_pos;
    assign w_word     = (w_cur_sel < 4'(TBL_DEPTH)) ? r_tbl[w_cur_sel[TBL_IDX_W-1:0]] : '0;
    assign w_shifted  = w_word << w_bp_sel;
    assign w_half0    = half_len(w_shifted[63], w_cfg);
    assign w_half1    = half_len(w_shifted[62], w_cfg);
    assign w_last_bit = ({1'b0, r_bit_pos} + 7'd1) >= w_eff_bits;

    // Next frame state and result for the accepted item.
    always_comb begin
        n_phase        = r_phase;
        n_half_timer   = r_half_timer;
        n_period_timer = r_period_timer;
        n_bit_pos      = r_bit_pos;
        n_cur_entry    = r_cur_entry;
        n_level        = r_level;
        n_out_item.line_level   = r_level;
        n_out_item.frame_active = (r_phase != PH_IDLE);
        n_out_item.frame_index  = r_cur_entry[2:0];

        if (w_tick) begin
            // Start of a frame: gap, or straight into the bits, or back to idle if the bit length is zero.
            if (w_start) begin
                n_cur_entry    = w_cur_sel;
                n_period_timer = w_cfg.frame_period_ticks;
                if (w_cfg.start_gap_ticks != 20'd0) begin
                    n_phase      = PH_GAP;
                    n_half_timer = w_cfg.start_gap_ticks;
                    n_level      = 1'b0;
                end else begin
                    n_bit_pos = 6'd0;
                    if (w_eff_bits == 7'd0) begin
                        n_phase     = PH_IDLE;
                        n_level     = 1'b1;
                        n_cur_entry = w_cur_next;
                    end else begin
                        n_phase      = PH_HIGH;
                        n_half_timer = w_half0;
                        n_level      = 1'b1;
                    end
                end
            end

            // Level driven during this tick.
            n_out_item.line_level   = (n_phase == PH_IDLE) ? 1'b1 : n_level;
            n_out_item.frame_active = (n_phase != PH_IDLE);
            n_out_item.frame_index  = n_cur_entry[2:0];

            // Count the tick and move to the next segment on expiry.
            if (n_phase != PH_IDLE) begin
                if (n_half_timer != 20'd0) begin
                    n_half_timer = n_half_timer - 20'd1;
                end
                if (n_half_timer == 20'd0) begin
                    case (n_phase)
                        PH_GAP: begin
                            n_bit_pos = 6'd0;
                            if (w_eff_bits == 7'd0) begin
                                n_phase     = PH_IDLE;
                                n_level     = 1'b1;
                                n_cur_entry = w_cur_next;
                            end else begin
                                n_phase      = PH_HIGH;
                                n_half_timer = w_half0;
                                n_level      = 1'b1;
                            end
                        end
                        PH_HIGH: begin
                            n_phase      = PH_LOW;
                            n_half_timer = w_half0;
                            n_level      = 1'b0;
                        end
                        PH_LOW: begin
                            if (w_last_bit) begin
                                n_phase     = PH_IDLE;
                                n_level     = 1'b1;
                                n_cur_entry = w_cur_next;
                            end else begin
                                n_bit_pos    = r_bit_pos + 6'd1;
                                n_phase      = PH_HIGH;
                                n_half_timer = w_half1;
                                n_level      = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end else begin
                n_level = 1'b1;
            end

            if (n_period_timer != 24'd0) begin
                n_period_timer = n_period_timer - 24'd1;
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_half_timer   <= '0;
            r_period_timer <= '0;
            r_bit_pos      <= '0;
            r_cur_entry    <= '0;
            r_level        <= 1'b1;
        end else begin
            r_phase        <= n_phase;
            r_half_timer   <= n_half_timer;
            r_period_timer <= n_period_timer;
            r_bit_pos      <= n_bit_pos;
            r_cur_entry    <= n_cur_entry;
            r_level        <= n_level;
        end
    end

    // Message table writes; entries beyond the depth are dropped.
    always_ff @(posedge i_clk) begin
        if (w_wr && ({4'd0, i_in_item.entry_index} < 7'(QUEUE_DEPTH))) begin
            r_tbl[i_in_item.entry_index[TBL_IDX_W-1:0]] <= i_in_item.entry_word;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    // The line is high whenever no frame is running.
    a_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> r_level)
        else $error("line low while idle");

    // The start gap always drives the line low.
    a_gap_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_GAP) |-> !r_level)
        else $error("line high during start gap");

    // A running segment always has time left on its timer.
    a_timer_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_half_timer != 20'd0))
        else $error("segment timer expired without advance");

endmodule
